/* design/sks_pkg.sv */
`default_nettype none

package sks_pkg;

   // Fixed field widths of the request and response channels.
   localparam int MODE_W   = 2;
   localparam int KEY_W    = 32;
   localparam int RANK_W   = 6;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 7;

   typedef enum logic [MODE_W-1:0] {
      MODE_INSERT = 2'd0,
      MODE_REMOVE = 2'd1,
      MODE_LOOKUP = 2'd2,
      MODE_READ   = 2'd3
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK       = 2'd0,
      STATUS_REJECTED = 2'd1,
      STATUS_FULL     = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_COMPARE,
      ST_UPDATE,
      ST_RESPOND
   } state_type;

   // Command broadcast to every cell of the row.
   typedef struct packed {
      logic load;    // capture compare flags against the held request
      logic ins;     // commit an insert: shift up from the insert point
      logic rem;     // commit a remove: shift down onto the removed slot
   } cell_cmd_type;

endpackage

`default_nettype wire

/* design/sks_req_if.sv */
`default_nettype none

interface sks_req_if;
   logic                          valid;
   logic                          ready;
   logic [sks_pkg::MODE_W-1:0]    mode;
   logic [sks_pkg::KEY_W-1:0]     key;
   logic [sks_pkg::RANK_W-1:0]    rank;

   modport source (output valid, output mode, output key, output rank, input ready);
   modport sink   (input valid, input mode, input key, input rank, output ready);
endinterface

`default_nettype wire

/* design/sks_rsp_if.sv */
`default_nettype none

interface sks_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [sks_pkg::STATUS_W-1:0]  status;
   logic [sks_pkg::KEY_W-1:0]     key_out;
   logic [sks_pkg::COUNT_W-1:0]   position;
   logic [sks_pkg::COUNT_W-1:0]   entry_count;

   modport source (output valid, output status, output key_out, output position,
                   output entry_count, input ready);
   modport sink   (input valid, input status, input key_out, input position,
                   input entry_count, output ready);
endinterface

`default_nettype wire

/* design/sorted_key_set_table.sv */
// A response turns valid in the respond state, reached through the compare
// and update states after a request is accepted in the idle state.
// A new request is taken only in the idle state, so the block accepts none
// until the previous response is taken; it passes through accept, compare,
// shift and respond in turn. Reset clears the key count and all control state;
// stored keys are left undefined and are never read until written.
`default_nettype none

module sorted_key_set_table #(
   parameter int CAPACITY  = 64,
   parameter int KEY_WIDTH = 32
) (
   input  wire          clock,
   input  wire          reset,
   sks_req_if.sink      req_chan,
   sks_rsp_if.source    rsp_chan
);

   // The count must hold the value CAPACITY itself.
   localparam int CNT_W = $clog2(CAPACITY + 1);

   sks_pkg::state_type    state_ff, state_in;
   sks_pkg::cell_cmd_type cmd;

   sks_pkg::mode_type               mode_ff;
   logic [KEY_WIDTH-1:0]            key_ff;
   logic [sks_pkg::RANK_W-1:0]      rank_ff;
   logic [CNT_W-1:0]                count_ff, count_in;

   logic [KEY_WIDTH+sks_pkg::KEY_W-1:0] key_wide;
   logic [KEY_WIDTH+sks_pkg::KEY_W-1:0] kout_wide;

   sks_pkg::status_type             status_ff, status_in;
   logic [sks_pkg::KEY_W-1:0]       key_out_ff, key_out_in;
   logic [sks_pkg::COUNT_W-1:0]     position_ff, position_in;

   // Per-cell signals; entry and lt also feed the neighbor cells, and the flags are gathered below.
   logic [KEY_WIDTH-1:0] entry [CAPACITY];
   logic [KEY_WIDTH-1:0] rsel  [CAPACITY];
   logic                 lt    [CAPACITY];
   logic                 eq    [CAPACITY];
   logic                 edge_bit [CAPACITY];

   logic                 hit, full;
   logic [CNT_W-1:0]     pos;
   logic [KEY_WIDTH-1:0] read_key;

   // The incoming key is reduced to its low KEY_WIDTH bits.
   assign key_wide = {{KEY_WIDTH{1'b0}}, req_chan.key};

   // ------------------------------------------------------------------
   // Cell row. Cell 0 sees "everything to the left is smaller", so the
   // insert point is the first cell whose key is not below the request.
   // The last cell shifts in its own key on a remove; it then lies past
   // the count and is never read.
   // ------------------------------------------------------------------
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [KEY_WIDTH-1:0] left_entry, right_entry;
      logic                 left_lt;

      if (i == 0) begin : g_first
         assign left_entry = key_ff;
         assign left_lt    = 1'b1;
      end else begin : g_inner
         assign left_entry = entry[i-1];
         assign left_lt    = lt[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign right_entry = entry[i];
      end else begin : g_notlast
         assign right_entry = entry[i+1];
      end

      sks_cell #(
         .KEY_WIDTH (KEY_WIDTH),
         .CNT_W     (CNT_W),
         .INDEX     (i)
      ) u_cell (
         .clock         (clock),
         .reset         (reset),
         .cmd_i         (cmd),
         .key_i         (key_ff),
         .rank_i        (rank_ff),
         .count_i       (count_ff),
         .left_entry_i  (left_entry),
         .left_lt_i     (left_lt),
         .right_entry_i (right_entry),
         .entry_o       (entry[i]),
         .lt_o          (lt[i]),
         .eq_o          (eq[i]),
         .edge_o        (edge_bit[i]),
         .rsel_o        (rsel[i])
      );
   end

   // Gather the cell flags. The edge bits are one-hot at the insert point
   // (or all clear when every held key is smaller and the table is full),
   // so the position is a plain OR encode. At most one cell matches the rank.
   always_comb begin
      hit      = 1'b0;
      pos      = '0;
      read_key = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         hit      = hit | eq[i];
         read_key = read_key | rsel[i];
         if (edge_bit[i]) begin
            pos = pos | CNT_W'(i);
         end
      end
   end

   // A stored zero key looks the same as no match on the OR bus, so the
   // rank is checked against the count directly.
   logic rank_ok;
   assign rank_ok = (CNT_W + sks_pkg::RANK_W)'(rank_ff) < (CNT_W + sks_pkg::RANK_W)'(count_ff);

   assign full = count_ff == CNT_W'(CAPACITY);

   // ------------------------------------------------------------------
   // Control: next state.
   // ------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sks_pkg::ST_IDLE: begin
            if (req_chan.valid) begin
               state_in = sks_pkg::ST_COMPARE;
            end
         end
         sks_pkg::ST_COMPARE: begin
            state_in = sks_pkg::ST_UPDATE;
         end
         sks_pkg::ST_UPDATE: begin
            state_in = sks_pkg::ST_RESPOND;
         end
         sks_pkg::ST_RESPOND: begin
            if (rsp_chan.ready) begin
               state_in = sks_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = sks_pkg::ST_IDLE;
         end
      endcase
   end

   // ------------------------------------------------------------------
   // Control: outputs and the cell command.
   // ------------------------------------------------------------------
   always_comb begin
      req_chan.ready = 1'b0;
      rsp_chan.valid = 1'b0;
      cmd            = '0;
      unique case (state_ff)
         sks_pkg::ST_IDLE: begin
            req_chan.ready = 1'b1;
         end
         sks_pkg::ST_COMPARE: begin
            cmd.load = 1'b1;
         end
         sks_pkg::ST_UPDATE: begin
            cmd.ins = (mode_ff == sks_pkg::MODE_INSERT) && !hit && !full;
            cmd.rem = (mode_ff == sks_pkg::MODE_REMOVE) && hit;
         end
         sks_pkg::ST_RESPOND: begin
            rsp_chan.valid = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sks_pkg::ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   // ------------------------------------------------------------------
   // Response build in the update cycle.
   // ------------------------------------------------------------------
   always_comb begin
      count_in    = count_ff;
      status_in   = sks_pkg::STATUS_REJECTED;
      key_out_in  = '0;
      position_in = '0;
      kout_wide   = '0;
      if (cmd.ins) begin
         count_in = count_ff + CNT_W'(1);
      end else if (cmd.rem) begin
         count_in = count_ff - CNT_W'(1);
      end

      unique case (mode_ff)
         sks_pkg::MODE_INSERT: begin
            if (hit) begin
               position_in = sks_pkg::COUNT_W'(pos);
            end else if (full) begin
               status_in = sks_pkg::STATUS_FULL;
            end else begin
               status_in   = sks_pkg::STATUS_OK;
               position_in = sks_pkg::COUNT_W'(pos);
            end
         end
         sks_pkg::MODE_REMOVE: begin
            if (hit) begin
               status_in   = sks_pkg::STATUS_OK;
               position_in = sks_pkg::COUNT_W'(pos);
            end
         end
         sks_pkg::MODE_LOOKUP: begin
            if (hit) begin
               status_in   = sks_pkg::STATUS_OK;
               kout_wide   = {{sks_pkg::KEY_W{1'b0}}, key_ff};
               key_out_in  = kout_wide[sks_pkg::KEY_W-1:0];
               position_in = sks_pkg::COUNT_W'(pos);
            end
         end
         sks_pkg::MODE_READ: begin
            if (rank_ok) begin
               status_in   = sks_pkg::STATUS_OK;
               kout_wide   = {{sks_pkg::KEY_W{1'b0}}, read_key};
               key_out_in  = kout_wide[sks_pkg::KEY_W-1:0];
               position_in = sks_pkg::COUNT_W'(rank_ff);
            end
         end
         default: begin
         end
      endcase
   end

   // Request and response payload registers.
   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         mode_ff <= sks_pkg::mode_type'(req_chan.mode);
         key_ff  <= key_wide[KEY_WIDTH-1:0];
         rank_ff <= req_chan.rank;
      end
      if (state_ff == sks_pkg::ST_UPDATE) begin
         status_ff   <= status_in;
         key_out_ff  <= key_out_in;
         position_ff <= position_in;
      end
   end

   assign rsp_chan.status      = status_ff;
   assign rsp_chan.key_out     = key_out_ff;
   assign rsp_chan.position    = position_ff;
   assign rsp_chan.entry_count = sks_pkg::COUNT_W'(count_ff);

endmodule

`default_nettype wire

/* design/sks_cell.sv */
`default_nettype none

// One slot of the sorted row. It compares its key with the request key and
// shifts toward or away from its neighbors when an insert or remove commits.
module sks_cell #(
   parameter int KEY_WIDTH = 32,
   parameter int CNT_W     = 7,
   parameter int INDEX     = 0
) (
   input  wire                         clock,
   input  wire                         reset,
   input  wire sks_pkg::cell_cmd_type  cmd_i,
   input  wire [KEY_WIDTH-1:0]         key_i,
   input  wire [sks_pkg::RANK_W-1:0]   rank_i,
   input  wire [CNT_W-1:0]             count_i,
   input  wire [KEY_WIDTH-1:0]         left_entry_i,
   input  wire                         left_lt_i,
   input  wire [KEY_WIDTH-1:0]         right_entry_i,
   output logic [KEY_WIDTH-1:0]        entry_o,
   output logic                        lt_o,
   output logic                        eq_o,
   output logic                        edge_o,
   output logic [KEY_WIDTH-1:0]        rsel_o
);

   logic [KEY_WIDTH-1:0] entry_ff, entry_in;
   logic                 lt_ff, eq_ff, rk_ff;
   logic                 slot_valid;

   assign slot_valid = int'(count_i) > INDEX;

   always_ff @(posedge clock) begin
      if (reset) begin
         lt_ff <= 1'b0;
         eq_ff <= 1'b0;
         rk_ff <= 1'b0;
      end else if (cmd_i.load) begin
         lt_ff <= slot_valid && (entry_ff < key_i);
         eq_ff <= slot_valid && (entry_ff == key_i);
         rk_ff <= slot_valid && (int'(rank_i) == INDEX);
      end
   end

   // Slots below the insert or remove point keep their key.
   always_comb begin
      entry_in = entry_ff;
      if (cmd_i.ins && !lt_ff) begin
         entry_in = left_lt_i ? key_i : left_entry_i;
      end else if (cmd_i.rem && !lt_ff) begin
         entry_in = right_entry_i;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry_o = entry_ff;
   assign lt_o    = lt_ff;
   assign eq_o    = eq_ff;
   assign edge_o  = left_lt_i && !lt_ff;
   assign rsel_o  = rk_ff ? entry_ff : '0;

endmodule

`default_nettype wire

/* bench/sks_table_checker.sv */
`timescale 1ns / 100ps

module sks_table_checker
   import sks_pkg::*;
#(
   parameter int CAPACITY  = 64,
   parameter int KEY_WIDTH = 32
) (
   input  wire  clock,
   input  wire  reset,
   sks_req_if   req_bus,
   sks_rsp_if   rsp_bus,
   output int   mismatches,
   output int   pending,
   output int   replies_checked,
   output int   rejects,
   output int   full_refusals
);

   localparam logic [KEY_W-1:0] KEY_MASK =
      (KEY_WIDTH >= KEY_W) ? '1 : KEY_W'((64'd1 << KEY_WIDTH) - 64'd1);

   typedef struct packed {
      status_type           status;
      logic [KEY_W-1:0]     key_out;
      logic [COUNT_W-1:0]   position;
      logic [COUNT_W-1:0]   entry_count;
   } table_reply_type;

   // Shadow of the sorted table; slots at and above held_count are never read.
   logic [KEY_W-1:0] held_keys [CAPACITY];
   int               held_count;
   table_reply_type  predicted_q [$];

   // Applies one request to the shadow table and returns the reply it must cause.
   function automatic table_reply_type table_update(mode_type op, logic [KEY_W-1:0] key_in,
                                                    logic [RANK_W-1:0] rank);
      table_reply_type r;
      logic [KEY_W-1:0] k;
      int slot;
      int i;
      bit hit;
      r.status   = STATUS_REJECTED;
      r.key_out  = '0;
      r.position = '0;
      k = key_in & KEY_MASK;
      slot = 0;
      while (slot < held_count && held_keys[slot] < k) slot++;
      hit = (slot < held_count) && (held_keys[slot] == k);
      case (op)
         MODE_INSERT: begin
            if (hit) begin
               r.position = COUNT_W'(slot);
            end else if (held_count >= CAPACITY) begin
               r.status = STATUS_FULL;
            end else begin
               for (i = held_count; i > slot; i--) held_keys[i] = held_keys[i-1];
               held_keys[slot] = k;
               held_count++;
               r.status   = STATUS_OK;
               r.position = COUNT_W'(slot);
            end
         end
         MODE_REMOVE: begin
            if (hit) begin
               for (i = slot; i + 1 < held_count; i++) held_keys[i] = held_keys[i+1];
               held_count--;
               r.status   = STATUS_OK;
               r.position = COUNT_W'(slot);
            end
         end
         MODE_LOOKUP: begin
            if (hit) begin
               r.status   = STATUS_OK;
               r.key_out  = k;
               r.position = COUNT_W'(slot);
            end
         end
         default: begin
            if (int'(rank) < held_count) begin
               r.status   = STATUS_OK;
               r.key_out  = held_keys[rank];
               r.position = COUNT_W'(rank);
            end
         end
      endcase
      r.entry_count = COUNT_W'(held_count);
      return r;
   endfunction

   always @(posedge clock) begin : watch
      table_reply_type want;
      table_reply_type got;
      if (reset) begin
         held_count = 0;
         predicted_q.delete();
         mismatches      = 0;
         replies_checked = 0;
         rejects         = 0;
         full_refusals   = 0;
      end else begin
         // Replies are checked before the request of this edge is queued.
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.status      = status_type'(rsp_bus.status);
            got.key_out     = rsp_bus.key_out;
            got.position    = rsp_bus.position;
            got.entry_count = rsp_bus.entry_count;
            if (predicted_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%t: unexpected reply: status %0d key %h pos %0d count %0d",
                           $realtime, got.status, got.key_out, got.position, got.entry_count);
            end else begin
               want = predicted_q.pop_front();
               replies_checked++;
               if (want.status == STATUS_REJECTED) rejects++;
               if (want.status == STATUS_FULL) full_refusals++;
               if (got.status !== want.status || got.key_out !== want.key_out ||
                   got.position !== want.position || got.entry_count !== want.entry_count) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $write("%t: reply mismatch: expected status %0d key %h pos %0d count %0d,",
                            $realtime, want.status, want.key_out, want.position,
                            want.entry_count);
                     $display(" got status %0d key %h pos %0d count %0d",
                              got.status, got.key_out, got.position, got.entry_count);
                  end
               end
            end
         end
         if (req_bus.valid && req_bus.ready)
            predicted_q.push_back(table_update(mode_type'(req_bus.mode), req_bus.key,
                                               req_bus.rank));
      end
      pending = predicted_q.size();
   end

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
   import sks_pkg::*;

   localparam int CAPACITY       = 64;
   localparam int KEY_WIDTH      = 32;
   localparam int REQUEST_TARGET = 1900;
   localparam int POOL_LIMIT     = 128;

   // The random part walks through three kinds of phase: one that fills the
   // table until it refuses, one that empties it again, and an even mix.
   typedef enum int {PH_FILL, PH_DRAIN, PH_MIXED} phase_kind_type;

   logic clock;
   logic reset;

   sks_req_if req_bus ();
   sks_rsp_if rsp_bus ();

   int mismatches;
   int pending;
   int replies_checked;
   int rejects;
   int full_refusals;

   int requests_sent;
   int burst_left;
   // Keys offered for insertion recently. Removes, lookups and some inserts draw
   // from here so that they hit keys that are really held.
   logic [KEY_W-1:0] key_pool [$];

   sorted_key_set_table #(
      .CAPACITY  (CAPACITY),
      .KEY_WIDTH (KEY_WIDTH)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   // The checker keeps its own copy of the table, predicts each reply from the
   // requests it sees accepted and compares the replies as they are taken.
   sks_table_checker #(
      .CAPACITY  (CAPACITY),
      .KEY_WIDTH (KEY_WIDTH)
   ) u_check (
      .clock           (clock),
      .reset           (reset),
      .req_bus         (req_bus),
      .rsp_bus         (rsp_bus),
      .mismatches      (mismatches),
      .pending         (pending),
      .replies_checked (replies_checked),
      .rejects         (rejects),
      .full_refusals   (full_refusals)
   );

   // A 4 ns clock; every input changes on the falling edge only.
   initial clock = 1'b0;
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // The reply side takes replies in windows of random length. Each window has
   // a style of its own: always ready, a coin flip per cycle, a fixed period,
   // or a long stall broken only now and then.
   initial begin : rsp_pacing
      int style;
      int window;
      int period;
      int tick;
      rsp_bus.ready = 1'b0;
      tick = 0;
      forever begin
         style  = $urandom_range(0, 3);
         window = $urandom_range(20, 160);
         period = $urandom_range(2, 6);
         repeat (window) begin
            @(negedge clock);
            case (style)
               0:       rsp_bus.ready = 1'b1;
               1:       rsp_bus.ready = 1'($urandom_range(0, 1));
               2:       rsp_bus.ready = ((tick % period) == 0);
               default: rsp_bus.ready = ($urandom_range(0, 7) == 0);
            endcase
            tick++;
         end
      end
   end

   // Sends one request. Requests go out in bursts; between bursts valid drops
   // for a random number of cycles while the payload carries junk, so gaps
   // land on every cycle of the block's compare and shift work. Within a
   // burst valid simply stays high from one request to the next.
   task automatic send_request(mode_type op, logic [KEY_W-1:0] key, logic [RANK_W-1:0] rank);
      if (burst_left == 0) begin
         req_bus.valid = 1'b0;
         req_bus.mode  = MODE_W'($urandom_range(0, 3));
         req_bus.key   = $urandom();
         req_bus.rank  = RANK_W'($urandom());
         repeat ($urandom_range(1, 8)) @(negedge clock);
         // Now and then a long burst gives a stretch with no idling at all.
         burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 12);
      end
      burst_left--;
      req_bus.valid = 1'b1;
      req_bus.mode  = op;
      req_bus.key   = key;
      req_bus.rank  = rank;
      if (op == MODE_INSERT) begin
         if (key_pool.size() >= POOL_LIMIT) void'(key_pool.pop_front());
         key_pool.push_back(key);
      end
      // The request is taken at the first rising edge with ready high.
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      requests_sent++;
      @(negedge clock);
   endtask

   // Chooses a key: from the pool with the given chance, otherwise one near
   // either end of the key range or a fully random one. A key taken for a
   // remove leaves the pool.
   function automatic logic [KEY_W-1:0] pick_key(int pool_pct, bit take_out);
      int idx;
      logic [KEY_W-1:0] k;
      if (key_pool.size() > 0 && $urandom_range(0, 99) < pool_pct) begin
         idx = $urandom_range(0, key_pool.size() - 1);
         k = key_pool[idx];
         if (take_out) key_pool.delete(idx);
         return k;
      end
      case ($urandom_range(0, 4))
         0:       k = KEY_W'($urandom_range(0, 7));
         1:       k = '1 - KEY_W'($urandom_range(0, 7));
         default: k = $urandom();
      endcase
      return k;
   endfunction

   initial begin : stimulus
      phase_kind_type phase;
      mode_type op;
      int phase_len;
      int n;
      int roll;
      int drain_cycles;
      logic [KEY_W-1:0] key;

      // Every input is known from time zero; reset is held high at the start.
      reset         = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.mode  = MODE_INSERT;
      req_bus.key   = '0;
      req_bus.rank  = '0;
      requests_sent = 0;
      burst_left    = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part. On the empty table a read, a lookup and a remove are rejected.
      send_request(MODE_READ,   '0, '0);
      send_request(MODE_LOOKUP, '0, '0);
      send_request(MODE_REMOVE, 32'h0000_0005, '0);
      // Inserts at the middle, the bottom, the top and between two held keys.
      send_request(MODE_INSERT, 32'h8000_0000, '0);
      send_request(MODE_INSERT, 32'h0000_0000, '0);
      send_request(MODE_INSERT, 32'hFFFF_FFFF, '0);
      send_request(MODE_INSERT, 32'h7FFF_FFFF, '0);
      // Duplicate inserts at both ends report the rank already held.
      send_request(MODE_INSERT, 32'h0000_0000, '0);
      send_request(MODE_INSERT, 32'hFFFF_FFFF, '1);
      send_request(MODE_LOOKUP, 32'hFFFF_FFFF, '0);
      send_request(MODE_LOOKUP, 32'h5555_5555, '0);
      // Reads at the first and last held rank, one past the end, and the
      // largest rank the field can carry.
      send_request(MODE_READ,   '1, 6'd0);
      send_request(MODE_READ,   '0, 6'd3);
      send_request(MODE_READ,   '0, 6'd4);
      send_request(MODE_READ,   '0, 6'd63);
      // Removes at both ends, then a remove of a key already gone.
      send_request(MODE_REMOVE, 32'h0000_0000, '0);
      send_request(MODE_REMOVE, 32'hFFFF_FFFF, '0);
      send_request(MODE_REMOVE, 32'hFFFF_FFFF, '0);
      send_request(MODE_READ,   '0, 6'd0);
      send_request(MODE_INSERT, 32'hAAAA_AAAA, '0);
      send_request(MODE_INSERT, 32'h5555_5555, '0);
      send_request(MODE_LOOKUP, 32'h7FFF_FFFF, '0);
      send_request(MODE_REMOVE, 32'h8000_0000, '0);
      send_request(MODE_READ,   '0, 6'd2);

      // Random part. A fill phase carries enough inserts to reach capacity, so
      // the full table is refused several times over the run; a drain phase
      // then removes mostly keys that are really held.
      phase = PH_FILL;
      while (requests_sent < REQUEST_TARGET) begin
         phase_len = $urandom_range(100, 130);
         for (n = 0; n < phase_len && requests_sent < REQUEST_TARGET; n++) begin
            roll = $urandom_range(0, 99);
            case (phase)
               PH_FILL:  op = (roll < 80) ? MODE_INSERT : (roll < 84) ? MODE_REMOVE :
                              (roll < 94) ? MODE_LOOKUP : MODE_READ;
               PH_DRAIN: op = (roll < 10) ? MODE_INSERT : (roll < 80) ? MODE_REMOVE :
                              (roll < 90) ? MODE_LOOKUP : MODE_READ;
               default:  op = mode_type'(roll / 25);
            endcase
            case (op)
               MODE_INSERT: key = pick_key((phase == PH_FILL) ? 5 : 20, 1'b0);
               MODE_REMOVE: key = pick_key((phase == PH_DRAIN) ? 85 : 50, 1'b1);
               MODE_LOOKUP: key = pick_key(60, 1'b0);
               default:     key = $urandom();
            endcase
            send_request(op, key, RANK_W'($urandom()));
         end
         case (phase)
            PH_FILL:  phase = PH_DRAIN;
            PH_DRAIN: phase = PH_MIXED;
            default:  phase = PH_FILL;
         endcase
      end
      req_bus.valid = 1'b0;

      // Wait for every predicted reply, then a little longer for strays.
      drain_cycles = 0;
      while (pending != 0 && drain_cycles < 4000) begin
         @(negedge clock);
         drain_cycles++;
      end
      repeat (16) @(negedge clock);

      $display("Sent %0d table requests; %0d replies compared, %0d of them rejections",
               requests_sent, replies_checked, rejects);
      $display("and %0d refusals of a full table; %0d mismatches, %0d replies missing.",
               full_refusals, mismatches, pending);
      if (mismatches == 0 && pending == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

   // Guard against a hung handshake: far beyond the slowest legal run.
   initial begin
      #2_000_000;
      $display("Timed out with %0d requests sent and %0d replies outstanding.",
               requests_sent, pending);
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

/* sorted_key_set_table.f */
design/sks_pkg.sv
design/sks_req_if.sv
design/sks_rsp_if.sv
design/sks_cell.sv
design/sorted_key_set_table.sv
bench/sks_table_checker.sv
bench/tb_top.sv
